/* sv/wap_pkg.sv */
// Package of shared types and constants for the windowed altitude percent filter.
`default_nettype none

package wap_pkg;

	localparam int SampleW   = 12;
	localparam int SampleMax = 4095;
	localparam int MeanW     = 12;
	localparam int PctW      = 10;
	localparam int DiffW     = 13;
	localparam int MagW      = 12;

	localparam int SpanLow   = 1241;
	localparam int SpanHigh  = 2482;
	localparam int Span      = SpanHigh - SpanLow;
	localparam int PctScale  = 100;
	localparam int PctLimit  = 330;

	// Reciprocal of Span scaled by PctScale; 2**PctShift exceeds any magnitude,
	// so the estimate is at most one below the true quotient.
	localparam int PctShift  = 13;
	localparam int PctRecip  = (PctScale << PctShift) / Span;
	localparam int PctRecipW = $clog2(PctRecip + 1);
	localparam int PctProdW  = MagW + PctRecipW;
	localparam int EstW      = 9;
	localparam int ScaledW   = $clog2(SampleMax * PctScale + 1);

	typedef struct packed {
		logic [SampleW-1:0] sample;
		logic               capture;
	} in_t;

	typedef struct packed {
		logic [MeanW-1:0]       mean;
		logic signed [PctW-1:0] percent;
	} out_t;

endpackage

`default_nettype wire

/* sv/wap_cell.sv */
// One cell of the sample window: holds a sample and passes it on at each shift.
`default_nettype none

module wap_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          shift,
	input  wire logic [wap_pkg::SampleW-1:0]   d,
	output logic      [wap_pkg::SampleW-1:0]   q
);

	logic [wap_pkg::SampleW-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

`default_nettype wire

/* sv/wap_mean.sv */
// Rounded window mean: reciprocal multiply stage followed by a one-step correction.
`default_nettype none

module wap_mean #(
	parameter  int WINDOW = 16,
	localparam int SumW   = $clog2(WINDOW * wap_pkg::SampleMax + 1)
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [SumW-1:0]             sum,
	output logic      [wap_pkg::MeanW-1:0]   mean
);

	localparam int NumW = $clog2(2 * WINDOW * wap_pkg::SampleMax + WINDOW + 1);
	localparam longint unsigned RecipM = (longint'(1) << NumW) / longint'(2 * WINDOW);
	localparam int RecipW = $clog2(RecipM + 1);
	localparam int ProdW  = NumW + RecipW;
	localparam logic [NumW-1:0]   DivD  = NumW'(2 * WINDOW);
	localparam logic [NumW-1:0]   HalfD = NumW'(WINDOW);
	localparam logic [RecipW-1:0] Recip = RecipW'(RecipM);

	logic [NumW-1:0]           num;
	logic [ProdW-1:0]          prod;
	logic [wap_pkg::MeanW-1:0] q_est_s2;
	logic [NumW-1:0]           num_s2;
	logic [NumW-1:0]           back;
	logic [NumW-1:0]           rem;

	assign num  = NumW'({sum, 1'b0}) + HalfD;
	assign prod = ProdW'(num) * ProdW'(Recip);

	always_ff @(posedge clk) begin
		if (en) begin
			q_est_s2 <= wap_pkg::MeanW'(prod >> NumW);
			num_s2   <= num;
		end
	end

	// The estimate is the quotient or one below it; the remainder decides.
	assign back = NumW'(q_est_s2) * DivD;
	assign rem  = num_s2 - back;
	assign mean = q_est_s2 + wap_pkg::MeanW'(rem >= DivD);

endmodule

`default_nettype wire

/* sv/wap_pct.sv */
// Altitude percent: scaled division by the span, truncated toward zero.
`default_nettype none

module wap_pct (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [wap_pkg::DiffW-1:0]  diff,
	output logic signed      [wap_pkg::PctW-1:0]   pct
);

	logic                           neg;
	logic signed [wap_pkg::DiffW-1:0] abs_diff;
	logic [wap_pkg::MagW-1:0]       mag;
	logic [wap_pkg::PctProdW-1:0]   prod;
	logic [wap_pkg::EstW-1:0]       est_s4;
	logic [wap_pkg::MagW-1:0]       mag_s4;
	logic                           neg_s4;
	logic [wap_pkg::ScaledW-1:0]    scaled;
	logic [wap_pkg::ScaledW-1:0]    back;
	logic [wap_pkg::ScaledW-1:0]    rem;
	logic [wap_pkg::EstW-1:0]       quo;
	logic signed [wap_pkg::PctW-1:0] quo_s;

	assign neg      = diff[wap_pkg::DiffW-1];
	assign abs_diff = neg ? -diff : diff;
	assign mag      = wap_pkg::MagW'(abs_diff);
	assign prod     = wap_pkg::PctProdW'(mag) * wap_pkg::PctProdW'(wap_pkg::PctRecip);

	always_ff @(posedge clk) begin
		if (en) begin
			est_s4 <= wap_pkg::EstW'(prod >> wap_pkg::PctShift);
			mag_s4 <= mag;
			neg_s4 <= neg;
		end
	end

	assign scaled = wap_pkg::ScaledW'(mag_s4) * wap_pkg::ScaledW'(wap_pkg::PctScale);
	assign back   = wap_pkg::ScaledW'(est_s4) * wap_pkg::ScaledW'(wap_pkg::Span);
	assign rem    = scaled - back;
	assign quo    = est_s4 + wap_pkg::EstW'(rem >= wap_pkg::ScaledW'(wap_pkg::Span));
	assign quo_s  = wap_pkg::PctW'(quo);
	assign pct    = neg_s4 ? -quo_s : quo_s;

endmodule

`default_nettype wire

/* sv/windowed_altitude_percent.sv */
// An accepted item's valid flag moves through v_s1, v_s2, v_s3, v_s4 and out_valid_q.
// Throughput: one item per cycle; the window cells shift and the running sum
// updates once per accepted item, and the whole pipeline stalls together.
// Reset clears the window cells, the running sum, the ground reference and
// all valid flags, so the first means count the empty cells as zeros.
`default_nettype none

module windowed_altitude_percent #(
	parameter int WINDOW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire wap_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output wap_pkg::out_t      out_data
);

	localparam int SumW = $clog2(WINDOW * wap_pkg::SampleMax + 1);

	logic                             en;
	logic                             accept;
	logic [wap_pkg::SampleW-1:0]      tap [WINDOW];
	logic [SumW-1:0]                  sum_q;
	logic                             v_s1, v_s2, v_s3, v_s4;
	logic                             cap_s1, cap_s2;
	logic [wap_pkg::MeanW-1:0]        mean_c;
	logic [wap_pkg::MeanW-1:0]        ground_q;
	logic signed [wap_pkg::DiffW-1:0] diff_c;
	logic [wap_pkg::MeanW-1:0]        mean_s3, mean_s4;
	logic signed [wap_pkg::DiffW-1:0] diff_s3;
	logic signed [wap_pkg::PctW-1:0]  pct_c;
	logic                             out_valid_q;
	wap_pkg::out_t                    out_q;

	assign en       = !out_valid_q || out_ready;
	assign accept   = in_valid && en;
	assign in_ready = en;

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				wap_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (accept),
					.d      (in_data.sample),
					.q      (tap[gi])
				);
			end else begin : g_link
				wap_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (accept),
					.d      (tap[gi-1]),
					.q      (tap[gi])
				);
			end
		end
	endgenerate

	// The last cell holds the sample that leaves the window on this item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (accept) begin
			sum_q <= sum_q - SumW'(tap[WINDOW-1]) + SumW'(in_data.sample);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cap_s1 <= in_data.capture;
			cap_s2 <= cap_s1;
		end
	end

	wap_mean #(
		.WINDOW (WINDOW)
	) u_mean (
		.clk  (clk),
		.en   (en),
		.sum  (sum_q),
		.mean (mean_c)
	);

	// A capturing item takes its own mean as reference, so its difference is zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ground_q <= '0;
		end else if (en && v_s2 && cap_s2) begin
			ground_q <= mean_c;
		end
	end

	assign diff_c = cap_s2 ? '0 : $signed({1'b0, ground_q}) - $signed({1'b0, mean_c});

	always_ff @(posedge clk) begin
		if (en) begin
			mean_s3 <= mean_c;
			diff_s3 <= diff_c;
			mean_s4 <= mean_s3;
		end
	end

	wap_pct u_pct (
		.clk  (clk),
		.en   (en),
		.diff (diff_s3),
		.pct  (pct_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.mean    <= mean_s4;
			out_q.percent <= pct_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_capture_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s2 && cap_s2 |=> diff_s3 == '0)
		else $error("capturing item did not give a zero difference");

	a_stall_holds_sum: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sum_q))
		else $error("running sum changed while the pipeline was stalled");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($signed(out_q.percent) <= wap_pkg::PctW'(wap_pkg::PctLimit)
			&& $signed(out_q.percent) >= -$signed(wap_pkg::PctW'(wap_pkg::PctLimit))))
		else $error("percent result out of range");

endmodule

`default_nettype wire

/* verif/tb_windowed_altitude_percent.sv */
// Self-checking testbench for the windowed altitude percent filter.
module tb_windowed_altitude_percent;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW     = 16;
	localparam int Latency    = 4;
	localparam int DrainSlack = Latency + 4;
	localparam int HoldCycles = 150;
	localparam int CycleLimit = 200000;
	localparam logic [6:0] RxPatternBits = 7'b1101011;

	typedef enum int {RxAlways, RxRandom, RxPattern} rx_mode_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	wap_pkg::in_t  in_data = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	wap_pkg::out_t out_data;

	// Predictor state, kept alongside the block.
	logic [wap_pkg::SampleW-1:0] window_cells [WINDOW];
	int unsigned                 oldest_slot;
	int unsigned                 running_sum;
	logic [wap_pkg::MeanW-1:0]   ground_ref;

	wap_pkg::out_t pending_results [$];

	int errors = 0;
	int items_sent = 0;
	int captures_sent = 0;
	int results_checked = 0;
	int cycle_count = 0;

	bit       sender_bursty = 1'b0;
	int       burst_left = 0;
	rx_mode_t rx_mode = RxAlways;
	bit       hold_request = 1'b0;
	int       hold_left = 0;
	int       rx_phase = 0;

	windowed_altitude_percent #(.WINDOW(WINDOW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advances the predicted window by one sample and forms the expected result.
	function automatic wap_pkg::out_t altitude_filter_step(input wap_pkg::in_t item);
		wap_pkg::out_t result;
		int            mean_val;
		int            diff;
		int            pct;
		running_sum = running_sum - window_cells[oldest_slot] + item.sample;
		window_cells[oldest_slot] = item.sample;
		oldest_slot = (oldest_slot == WINDOW - 1) ? 0 : oldest_slot + 1;
		mean_val = (2 * running_sum + WINDOW) / (2 * WINDOW);
		mean_val = mean_val & wap_pkg::SampleMax;
		if (item.capture) begin
			ground_ref = mean_val[wap_pkg::MeanW-1:0];
		end
		// Integer division in SystemVerilog truncates toward zero.
		diff = int'(ground_ref) - mean_val;
		pct = (diff * wap_pkg::PctScale) / wap_pkg::Span;
		result.mean = mean_val[wap_pkg::MeanW-1:0];
		result.percent = pct[wap_pkg::PctW-1:0];
		return result;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at cycle %0d, %s: got %0d, expected %0d", cycle_count, what, got, want);
		errors++;
	endtask

	task automatic pace_sender();
		if (sender_bursty) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_sample(input logic [wap_pkg::SampleW-1:0] value, input logic cap);
		wap_pkg::in_t item;
		item.sample = value;
		item.capture = cap;
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(altitude_filter_step(item));
		items_sent++;
		if (cap) begin
			captures_sent++;
		end
		pace_sender();
	endtask

	// Holds the sender back until every expected result has arrived.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DrainSlack) @(posedge clk);
	endtask

	// Mostly runs of samples around a level, as a sensor settling at an altitude,
	// with occasional captures; the rest is uniform noise.
	task automatic send_random_items(input int count);
		int sent;
		int level;
		int spread;
		int run_len;
		int offset;
		int value;
		logic cap;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 9))
				0: level = 0;
				1: level = wap_pkg::SampleMax;
				default: level = $urandom_range(0, wap_pkg::SampleMax);
			endcase
			case ($urandom_range(0, 4))
				0: spread = 0;
				1: spread = 8;
				2: spread = 64;
				3: spread = 512;
				default: spread = -1;
			endcase
			run_len = $urandom_range(4, 40);
			for (int i = 0; i < run_len && sent < count; i++) begin
				if (spread < 0) begin
					value = $urandom_range(0, wap_pkg::SampleMax);
				end else begin
					offset = $urandom_range(0, 2 * spread);
					value = level + offset - spread;
					if (value < 0) value = 0;
					if (value > wap_pkg::SampleMax) value = wap_pkg::SampleMax;
				end
				cap = ($urandom_range(0, 19) == 0);
				send_sample(value[wap_pkg::SampleW-1:0], cap);
				sent++;
			end
		end
	endtask

	// The window starts out full of zeros.
	task automatic test_startup();
		rx_mode = RxRandom;
		send_sample(12'hAAA, 1'b0);
		send_sample(12'h555, 1'b0);
		wait_for_results();
	endtask

	// Fills the window with full scale and wraps the write slot past the end.
	task automatic test_full_scale_wrap();
		for (int i = 0; i < WINDOW; i++) begin
			send_sample(wap_pkg::SampleW'(wap_pkg::SampleMax), 1'b0);
		end
		wait_for_results();
	endtask

	// A capture latches the new mean before the percent is formed.
	task automatic test_capture_same_step();
		send_sample(wap_pkg::SampleW'(wap_pkg::SampleMax), 1'b1);
		for (int i = 0; i < 4; i++) begin
			send_sample('0, 1'b0);
		end
		send_sample('0, 1'b1);
		wait_for_results();
	endtask

	task automatic test_back_to_back();
		sender_bursty = 1'b0;
		rx_mode = RxAlways;
		send_random_items(150);
		wait_for_results();
	endtask

	task automatic test_bursty_random_ready();
		sender_bursty = 1'b1;
		rx_mode = RxRandom;
		send_random_items(330);
		wait_for_results();
	endtask

	task automatic test_bursty_pattern_ready();
		sender_bursty = 1'b1;
		rx_mode = RxPattern;
		send_random_items(330);
		wait_for_results();
	endtask

	// The receiver stops for a long stretch while items keep coming, so the
	// pipeline fills and the input stalls.
	task automatic test_backpressure();
		sender_bursty = 1'b0;
		rx_mode = RxRandom;
		hold_request = 1'b1;
		send_random_items(60);
		wait_for_results();
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HoldCycles;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RxAlways: out_ready <= 1'b1;
				RxRandom: out_ready <= ($urandom_range(0, 99) < 70);
				default: begin
					rx_phase = (rx_phase + 1) % 7;
					out_ready <= RxPatternBits[rx_phase];
				end
			endcase
		end
	end

	always @(posedge clk) begin
		wap_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected, mean", out_data.mean, -1);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (out_data.mean !== want.mean) begin
					report_mismatch("mean", out_data.mean, want.mean);
				end
				if (out_data.percent !== want.percent) begin
					report_mismatch("percent", $signed(out_data.percent), $signed(want.percent));
				end
			end
		end
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding",
			cycle_count, pending_results.size());
		$display("windowed_altitude_percent test failed");
		$finish;
	end

	initial begin
		for (int i = 0; i < WINDOW; i++) begin
			window_cells[i] = '0;
		end
		oldest_slot = 0;
		running_sum = 0;
		ground_ref = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_startup();
		test_full_scale_wrap();
		test_capture_same_step();
		test_back_to_back();
		test_bursty_random_ready();
		test_bursty_pattern_ready();
		test_backpressure();

		$display("Sent %0d samples (%0d with capture) and checked %0d results, %0d mismatches.",
			items_sent, captures_sent, results_checked, errors);
		$display("Covered start-up, full scale, slot wrap, same-step capture, bursts and stalls.");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("windowed_altitude_percent test passed");
		end else begin
			$display("windowed_altitude_percent test failed");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/wap_pkg.sv
sv/wap_cell.sv
sv/wap_mean.sv
sv/wap_pct.sv
sv/windowed_altitude_percent.sv
verif/tb_windowed_altitude_percent.sv
